>>> src/double_to_decimal_text_macros.svh
// Assertion macros shared by the formatter RTL.
`ifndef DOUBLE_TO_DECIMAL_TEXT_MACROS_SVH
`define DOUBLE_TO_DECIMAL_TEXT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DTDT_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DTDT_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

>>> src/dtdt_pkg.sv
// Shared types, constants and the power-of-ten ROM for the decimal text formatter.
`timescale 1ns / 1ps
package dtdt_pkg;

  localparam int PIPE_STAGES = 14;
  localparam int N_W = 48;
  localparam int POW_MIN = -296;
  localparam int POW_COUNT = 605;
  localparam int POW_IDX_W = 10;
  localparam int BIG_W = 1104;
  localparam int RECIP_SHIFT = 1100;

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [16:0] LOG10_2_MUL = 17'd78913;
  localparam logic signed [9:0] TINY_K = 10'(12 - 308);
  localparam logic [9:0] TINY_BIASED = 10'((12 - 308) + 310);
  localparam logic [9:0] EXP_BIAS10 = 10'd310;
  localparam logic [N_W-1:0] LEAD_LIMIT = 48'd10000000000000;

  typedef enum logic [1:0] {
    CLS_NORMAL,
    CLS_ZERO,
    CLS_SPECIAL
  } cls_t;

  typedef struct packed {
    logic       neg;
    cls_t       cls;
    logic [9:0] biased;
  } tag_t;

  typedef struct packed {
    logic        neg;
    cls_t        cls;
    logic        exp_neg;
    logic [11:0] exp_bcd;
  } tail_t;

  typedef logic [POW_COUNT-1:0][63:0]  pow_tab_t;
  typedef logic [POW_COUNT-1:0][127:0] pow_pair_t;

  function automatic logic [63:0] round_to_double(logic [BIG_W-1:0] mag, int scale,
                                                  logic inexact);
    int          m;
    int          expf;
    logic [52:0] mant;
    logic [53:0] mr;
    logic        g;
    logic        st;
    logic [BIG_W-1:0] low;
    logic [51:0] fr;
    m = 0;
    for (int i = 0; i < BIG_W; i++) begin
      if (mag[i]) m = i;
    end
    if (m >= 53) begin
      mant = 53'(mag >> (m - 52));
      g = mag[m - 53];
      low = mag << (BIG_W - (m - 53));
      st = inexact || (low != '0);
    end else begin
      mant = 53'(mag << (52 - m));
      g = 1'b0;
      st = inexact;
    end
    mr = {1'b0, mant} + 54'(g && (st || mant[0]));
    if (mr[53]) begin
      m = m + 1;
      fr = 52'd0;
    end else begin
      fr = mr[51:0];
    end
    expf = m - scale + 1023;
    return {1'b0, 11'(expf), fr};
  endfunction

  function automatic pow_tab_t build_pow_table();
    pow_tab_t         tab;
    logic [BIG_W-1:0] acc;
    acc = BIG_W'(1);
    for (int p = 0; p < POW_COUNT + POW_MIN; p++) begin
      tab[p - POW_MIN] = round_to_double(acc, 0, 1'b0);
      acc = acc * 10;
    end
    acc = BIG_W'(1) << RECIP_SHIFT;
    for (int n = 1; n <= -POW_MIN; n++) begin
      acc = acc / 10;
      tab[-POW_MIN - n] = round_to_double(acc, RECIP_SHIFT, 1'b1);
    end
    return tab;
  endfunction

  function automatic pow_pair_t build_pair_table();
    pow_tab_t  tab;
    pow_pair_t pr;
    tab = build_pow_table();
    pr[0] = '0;
    for (int q = 1; q < POW_COUNT; q++) begin
      pr[q] = {tab[q], tab[q-1]};
    end
    return pr;
  endfunction

  localparam pow_pair_t POW_PAIR = build_pair_table();

endpackage

>>> src/dtdt_decode.sv
// Field decode, decimal exponent estimate and power-of-ten ROM read.
`timescale 1ns / 1ps
module dtdt_decode (
  input  logic                 clk,
  input  logic [1:0]           en,
  input  logic [63:0]          value_bits,
  output dtdt_pkg::tag_t       tag,
  output logic [52:0]          ma,
  output logic signed [11:0]   ea,
  output logic [63:0]          s1,
  output logic [63:0]          s2
);
  import dtdt_pkg::*;

  logic [10:0]         ebits;
  logic [51:0]         frac;
  logic                is_nan;
  logic signed [11:0]  e_unb;
  logic [9:0]          e_mag;
  logic [26:0]         prod;
  logic [8:0]          f;
  logic signed [9:0]   k;
  logic                tiny;
  logic [10:0]         q_wide;
  logic [10:0]         b_wide;
  tag_t                tag_next;
  logic [POW_IDX_W-1:0] q_next;

  logic [POW_IDX_W-1:0] q0;
  logic [52:0]          ma0;
  logic signed [11:0]   ea0;
  logic [127:0]         pair;

  always_comb begin
    ebits = value_bits[62:52];
    frac = value_bits[51:0];
    is_nan = (ebits == EXP_ALL_ONES) && (frac != 52'd0);
    e_unb = $signed({1'b0, ebits}) - 12'sd1023;
    e_mag = e_unb[11] ? 10'(-e_unb) : 10'(e_unb);
    prod = 27'(e_mag) * 27'(LOG10_2_MUL);
    f = prod[26:18];
    k = e_unb[11] ? (-$signed({1'b0, f}) - 10'sd1) : $signed({1'b0, f});
    tiny = (k <= TINY_K);
    q_wide = 11'd308 - {k[9], k};
    b_wide = {k[9], k} + 11'd310;
    q_next = tiny ? POW_IDX_W'(POW_COUNT - 1) : q_wide[POW_IDX_W-1:0];
    tag_next.neg = value_bits[63] && !is_nan && (value_bits[62:0] != 63'd0);
    if (ebits == 11'd0) begin
      tag_next.cls = CLS_ZERO;
    end else if (ebits == EXP_ALL_ONES) begin
      tag_next.cls = CLS_SPECIAL;
    end else begin
      tag_next.cls = CLS_NORMAL;
    end
    tag_next.biased = tiny ? TINY_BIASED : b_wide[9:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      tag <= tag_next;
      q0 <= q_next;
      ma0 <= {1'b1, frac};
      ea0 <= e_unb;
    end
    if (en[1]) begin
      pair <= POW_PAIR[q0];
      ma <= ma0;
      ea <= ea0;
    end
  end

  assign s1 = pair[127:64];
  assign s2 = pair[63:0];

endmodule

>>> src/dtdt_fmul.sv
// Pipelined binary64 multiply with nearest-even rounding, then half-up rounding to integer.
`timescale 1ns / 1ps
module dtdt_fmul (
  input  logic                      clk,
  input  logic [3:0]                en,
  input  logic [52:0]               ma,
  input  logic signed [11:0]        ea,
  input  logic [63:0]               scale,
  output logic [dtdt_pkg::N_W-1:0]  n
);
  import dtdt_pkg::*;

  logic [52:0]         mb;
  logic signed [12:0]  e_sum;
  logic [51:0]         hh;
  logic [52:0]         hl;
  logic [52:0]         lh;
  logic [53:0]         ll;
  logic signed [12:0]  e2;

  logic [105:0]        prod_next;
  logic [105:0]        prod;
  logic signed [12:0]  e3;

  logic [52:0]         mant;
  logic                g;
  logic                st;
  logic [53:0]         m_next;
  logic signed [12:0]  er_next;
  logic [53:0]         m4;
  logic signed [12:0]  er4;

  logic signed [12:0]  d_full;
  logic [5:0]          sh;
  logic [53:0]         r;
  logic [54:0]         r_inc;

  always_comb begin
    mb = {1'b1, scale[51:0]};
    e_sum = $signed({ea[11], ea}) + $signed({2'b00, scale[62:52]}) - 13'sd1023;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hh <= ma[52:27] * mb[52:27];
      hl <= 53'(ma[52:27] * mb[26:0]);
      lh <= 53'(ma[26:0] * mb[52:27]);
      ll <= ma[26:0] * mb[26:0];
      e2 <= e_sum;
    end
  end

  assign prod_next = {hh, 54'd0} + ((106'(hl) + 106'(lh)) << 27) + 106'(ll);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      prod <= prod_next;
      e3 <= e2;
    end
  end

  always_comb begin
    if (prod[105]) begin
      mant = prod[105:53];
      g = prod[52];
      st = (prod[51:0] != 52'd0);
      er_next = e3 + 13'sd1;
    end else begin
      mant = prod[104:52];
      g = prod[51];
      st = (prod[50:0] != 51'd0);
      er_next = e3;
    end
    m_next = {1'b0, mant} + 54'(g && (st || mant[0]));
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      m4 <= m_next;
      er4 <= er_next;
    end
  end

  always_comb begin
    d_full = 13'sd52 - er4;
    if (d_full < 13'sd1) begin
      sh = 6'd0;
    end else if (d_full > 13'sd63) begin
      sh = 6'd62;
    end else begin
      sh = 6'(d_full - 13'sd1);
    end
    r = m4 >> sh;
    r_inc = 55'(r) + 55'd1;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      n <= r_inc[N_W:1];
    end
  end

endmodule

>>> src/dtdt_select.sv
// Pick the scaled integer that fits thirteen digits and form the printed exponent.
`timescale 1ns / 1ps
module dtdt_select (
  input  logic                      clk,
  input  logic                      en,
  input  logic [dtdt_pkg::N_W-1:0]  n1,
  input  logic [dtdt_pkg::N_W-1:0]  n2,
  input  dtdt_pkg::tag_t            tag_in,
  output logic [dtdt_pkg::N_W-1:0]  n,
  output dtdt_pkg::tail_t           tail
);
  import dtdt_pkg::*;

  logic       ge;
  logic [9:0] bt;
  logic [9:0] ex;
  tail_t      tail_next;

  function automatic logic [11:0] bin9_to_bcd(logic [8:0] b);
    logic [11:0] r;
    r = 12'd0;
    for (int i = 8; i >= 0; i--) begin
      for (int d = 0; d < 3; d++) begin
        if (r[4*d +: 4] >= 4'd5) r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
      r = {r[10:0], b[i]};
    end
    return r;
  endfunction

  always_comb begin
    ge = (n1 >= LEAD_LIMIT);
    bt = tag_in.biased + 10'(ge);
    tail_next.neg = tag_in.neg;
    tail_next.cls = tag_in.cls;
    tail_next.exp_neg = (bt < EXP_BIAS10);
    ex = tail_next.exp_neg ? (EXP_BIAS10 - bt) : (bt - EXP_BIAS10);
    tail_next.exp_bcd = bin9_to_bcd(ex[8:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n <= ge ? n2 : n1;
      tail <= tail_next;
    end
  end

endmodule

>>> src/dtdt_bcd.sv
// Six-stage binary to decimal conversion, eight bits per stage.
`timescale 1ns / 1ps
module dtdt_bcd (
  input  logic                      clk,
  input  logic [5:0]                en,
  input  logic [dtdt_pkg::N_W-1:0]  n,
  output logic [51:0]               digits
);
  import dtdt_pkg::*;

  logic [59:0]    bcd_q [6];
  logic [N_W-1:0] n_q   [6];

  function automatic logic [59:0] dabble8(logic [59:0] b, logic [7:0] bits);
    logic [59:0] r;
    r = b;
    for (int i = 7; i >= 0; i--) begin
      for (int d = 0; d < 15; d++) begin
        if (r[4*d +: 4] >= 4'd5) r[4*d +: 4] = r[4*d +: 4] + 4'd3;
      end
      r = {r[58:0], bits[i]};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en[0]) begin
      bcd_q[0] <= dabble8(60'd0, n[N_W-1 -: 8]);
      n_q[0] <= n;
    end
  end

  for (genvar j = 1; j < 6; j++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en[j]) begin
        bcd_q[j] <= dabble8(bcd_q[j-1], n_q[j-1][N_W-1-8*j -: 8]);
        n_q[j] <= n_q[j-1];
      end
    end
  end

  assign digits = bcd_q[5][51:0];

endmodule

>>> src/double_to_decimal_text.sv
// The pipe has 14 register stages: decode, multiply, select, BCD and the text register.
// One item per cycle unless stalled, set by the pipelined multiply and decimal stages.
// A stalled output holds; upstream stages with free slots keep filling until the pipe is full.
// Reset: synchronous, clears all stage valid bits; the power-of-ten ROM is constant logic.
// Top level: binary64 pattern in, fixed 20-character scientific text out.
`timescale 1ns / 1ps
`include "double_to_decimal_text_macros.svh"
module double_to_decimal_text (
  input  logic        clk,
  input  logic        rst,
  input  logic        value_valid,
  output logic        value_stall,
  input  logic [63:0] value_bits,
  output logic        text_valid,
  input  logic        text_stall,
  output logic [63:0] text_head,
  output logic [63:0] text_middle,
  output logic [31:0] text_tail
);
  import dtdt_pkg::*;

  logic [PIPE_STAGES-1:0] v;
  logic [PIPE_STAGES-1:0] en;

  tag_t               tag0;
  tag_t               tag_q [1:5];
  tail_t              tail6;
  tail_t              tail_q [7:12];
  logic [52:0]        ma;
  logic signed [11:0] ea;
  logic [63:0]        s1;
  logic [63:0]        s2;
  logic [N_W-1:0]     n1;
  logic [N_W-1:0]     n2;
  logic [N_W-1:0]     n6;
  logic [51:0]        digits;

  logic [19:0][7:0]   text_next;
  logic [159:0]       text_q;
  tail_t              tl;

  always_comb begin
    en[PIPE_STAGES-1] = !v[PIPE_STAGES-1] || !text_stall;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign value_stall = !en[0];
  assign text_valid = v[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= value_valid;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  dtdt_decode u_decode (
    .clk        (clk),
    .en         (en[1:0]),
    .value_bits (value_bits),
    .tag        (tag0),
    .ma         (ma),
    .ea         (ea),
    .s1         (s1),
    .s2         (s2)
  );

  dtdt_fmul u_fmul_lo (
    .clk   (clk),
    .en    (en[5:2]),
    .ma    (ma),
    .ea    (ea),
    .scale (s1),
    .n     (n1)
  );

  dtdt_fmul u_fmul_hi (
    .clk   (clk),
    .en    (en[5:2]),
    .ma    (ma),
    .ea    (ea),
    .scale (s2),
    .n     (n2)
  );

  dtdt_select u_select (
    .clk    (clk),
    .en     (en[6]),
    .n1     (n1),
    .n2     (n2),
    .tag_in (tag_q[5]),
    .n      (n6),
    .tail   (tail6)
  );

  dtdt_bcd u_bcd (
    .clk    (clk),
    .en     (en[12:7]),
    .n      (n6),
    .digits (digits)
  );

  always_ff @(posedge clk) begin
    if (en[1]) tag_q[1] <= tag0;
    for (int i = 2; i <= 5; i++) begin
      if (en[i]) tag_q[i] <= tag_q[i-1];
    end
    if (en[7]) tail_q[7] <= tail6;
    for (int i = 8; i <= 12; i++) begin
      if (en[i]) tail_q[i] <= tail_q[i-1];
    end
  end

  always_comb begin
    tl = tail_q[12];
    text_next[19] = tl.neg ? "-" : "+";
    text_next[17] = ".";
    text_next[4] = "e";
    case (tl.cls)
      CLS_NORMAL: begin
        text_next[18] = {4'h3, digits[51:48]};
        for (int i = 0; i < 12; i++) begin
          text_next[16-i] = {4'h3, digits[4*(11-i) +: 4]};
        end
        text_next[3] = tl.exp_neg ? "-" : "+";
        text_next[2] = {4'h3, tl.exp_bcd[11:8]};
        text_next[1] = {4'h3, tl.exp_bcd[7:4]};
        text_next[0] = {4'h3, tl.exp_bcd[3:0]};
      end
      CLS_SPECIAL: begin
        text_next[18] = "1";
        for (int i = 0; i < 12; i++) begin
          text_next[16-i] = "0";
        end
        text_next[3] = "+";
        text_next[2] = "3";
        text_next[1] = "1";
        text_next[0] = "0";
      end
      default: begin
        text_next[18] = "0";
        for (int i = 0; i < 12; i++) begin
          text_next[16-i] = "0";
        end
        text_next[3] = "+";
        text_next[2] = "0";
        text_next[1] = "0";
        text_next[0] = "0";
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[PIPE_STAGES-1]) begin
      text_q <= text_next;
    end
  end

  assign text_head = text_q[159:96];
  assign text_middle = text_q[95:32];
  assign text_tail = text_q[31:0];

  `DTDT_ASSERT_IMPLY(a_stall_only_when_full, value_stall, v[0], "input stalled with stage 0 empty")
  `DTDT_ASSERT_IMPLY(a_text_dot, text_valid, text_head[47:40] == 8'h2E, "missing decimal point")
  `DTDT_ASSERT_IMPLY(a_text_e, text_valid, text_middle[7:0] == 8'h65, "missing exponent mark")
  `DTDT_ASSERT_NEXT(a_lead_range, en[7] && v[6] && tail6.cls == CLS_NORMAL, u_bcd.n_q[0] <= LEAD_LIMIT, "selected integer exceeds thirteen digits")

endmodule
